// ===== design/prqs_pkg.sv =====
// Package for the ready-queue scheduler: sizes, command and state codes, FSM type.
// No dependencies.
package prqs_pkg;
  localparam int NumTasks = 16;
  localparam int NumPrios = 8;
  localparam int TidW = 4;
  localparam int PrioW = 3;

  typedef enum logic [1:0] {
    FN_CREATE = 2'd0,
    FN_DELETE = 2'd1,
    FN_QUERY  = 2'd2,
    FN_RESCHED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_READY = 2'd1,
    ST_RUNNING = 2'd2,
    ST_DELETED = 2'd3
  } tstate_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic link;
    logic out_load;
  } cmd_t;
endpackage

// ===== design/prqs_if.sv =====
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
interface prqs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] task_id;
  logic [2:0] prio;
  modport source(output valid, func, task_id, prio, input ready);
  modport sink(input valid, func, task_id, prio, output ready);
endinterface

interface prqs_rsp_if;
  logic       valid;
  logic       ready;
  logic       error;
  logic [1:0] task_status;
  logic [3:0] running_task;
  logic       switch_request;
  modport source(output valid, error, task_status, running_task, switch_request, input ready);
  modport sink(input valid, error, task_status, running_task, switch_request, output ready);
endinterface

// ===== design/prqs_ctrl.sv =====
// Controller FSM: sequences load, decode/first update, link update, result load.
// Depends on prqs_pkg.
module prqs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_busy,
  output prqs_pkg::cmd_t    cmd
);
  prqs_pkg::fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= prqs_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      prqs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = prqs_pkg::S_EXEC;
        end
      end
      prqs_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = prqs_pkg::S_LINK;
      end
      prqs_pkg::S_LINK: begin
        cmd.link = 1'b1;
        state_next = prqs_pkg::S_OUT;
      end
      prqs_pkg::S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = prqs_pkg::S_IDLE;
        end
      end
      default: state_next = prqs_pkg::S_IDLE;
    endcase
  end
endmodule

// ===== design/prqs_dp.sv =====
// Datapath: task tables, queue heads, priority search and link updates.
// Depends on prqs_pkg.
module prqs_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  prqs_pkg::cmd_t              cmd,
  input  logic [1:0]                  in_func,
  input  logic [prqs_pkg::TidW-1:0]   in_tid,
  input  logic [prqs_pkg::PrioW-1:0]  in_prio,
  output logic                        r_error,
  output logic [1:0]                  r_status,
  output logic [prqs_pkg::TidW-1:0]   r_running,
  output logic                        r_switch
);
  localparam int TW = prqs_pkg::TidW;
  localparam int PW = prqs_pkg::PrioW;
  localparam int NT = prqs_pkg::NumTasks;
  localparam int NP = prqs_pkg::NumPrios;
  localparam logic [PW-1:0] Lowest = PW'(NP - 1);

  logic [TW-1:0]   next_link [NT];
  logic [TW-1:0]   prev_link [NT];
  logic [PW-1:0]   task_level [NT];
  prqs_pkg::tstate_t task_state [NT];
  logic [TW-1:0]   queue_head [NP];
  logic [NP-1:0]   queue_nonempty;
  logic [TW-1:0]   current_task;

  logic [1:0]    func;
  logic [TW-1:0] tid;
  logic [PW-1:0] prio;
  logic          err, sw;

  // Second-phase link operation latched in exec.
  logic          do_append;
  logic [PW-1:0] app_lvl;
  logic [TW-1:0] app_t;

  // Priority search (narrow, independent per level).
  logic          found;
  logic [PW-1:0] found_lvl;
  always_comb begin
    found = 1'b0;
    found_lvl = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (queue_nonempty[i] && (PW'(i) <= task_level[current_task])) begin
        found = 1'b1;
        found_lvl = PW'(i);
      end
    end
  end

  logic [TW-1:0] u_t, u_n, u_p, hd;
  logic [PW-1:0] u_lvl;
  logic          u_do;
  prqs_pkg::tstate_t ts;
  logic          bad_create, bad_delete;
  always_comb begin
    ts = task_state[tid];
    bad_create = (tid == current_task) || ts == prqs_pkg::ST_READY ||
                 ts == prqs_pkg::ST_RUNNING;
    bad_delete = ts == prqs_pkg::ST_FREE || ts == prqs_pkg::ST_DELETED;
    hd = queue_head[found_lvl];
    u_do = 1'b0;
    u_t = tid;
    u_lvl = task_level[tid];
    case (func)
      prqs_pkg::FN_DELETE: u_do = !bad_delete && ts == prqs_pkg::ST_READY;
      prqs_pkg::FN_RESCHED: begin
        u_do = found;
        u_t = hd;
        u_lvl = found_lvl;
      end
      default: u_do = 1'b0;
    endcase
    u_n = next_link[u_t];
    u_p = prev_link[u_t];
  end

  logic [TW-1:0] a_h, a_tail;
  always_comb begin
    a_h = queue_head[app_lvl];
    a_tail = prev_link[a_h];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NT; t++) begin
        next_link[t] <= TW'(t);
        prev_link[t] <= TW'(t);
        task_level[t] <= Lowest;
        task_state[t] <= (t == 0) ? prqs_pkg::ST_RUNNING : prqs_pkg::ST_FREE;
      end
      for (int p = 0; p < NP; p++) queue_head[p] <= '0;
      queue_nonempty <= '0;
      current_task <= '0;
      do_append <= 1'b0;
    end else begin
      if (cmd.load) begin
        func <= in_func;
        tid <= in_tid;
        prio <= in_prio;
      end
      if (cmd.exec) begin
        err <= 1'b0;
        sw <= 1'b0;
        do_append <= 1'b0;
        if (u_do) begin
          // unlink u_t from its level
          if (queue_nonempty[u_lvl] && queue_head[u_lvl] == u_t) begin
            if (u_n == u_t) queue_nonempty[u_lvl] <= 1'b0;
            else queue_head[u_lvl] <= u_n;
          end
          next_link[u_p] <= u_n;
          prev_link[u_n] <= u_p;
        end
        case (func)
          prqs_pkg::FN_CREATE: begin
            if (bad_create) err <= 1'b1;
            else begin
              do_append <= 1'b1;
              app_lvl <= prio;
              app_t <= tid;
              task_level[tid] <= prio;
              task_state[tid] <= prqs_pkg::ST_READY;
            end
          end
          prqs_pkg::FN_DELETE: begin
            if (bad_delete) err <= 1'b1;
            else begin
              if (tid == current_task) sw <= 1'b1;
              task_state[tid] <= prqs_pkg::ST_DELETED;
              task_level[tid] <= Lowest;
            end
          end
          prqs_pkg::FN_RESCHED: begin
            if (found) begin
              if (task_state[current_task] != prqs_pkg::ST_DELETED) begin
                do_append <= 1'b1;
                app_lvl <= task_level[current_task];
                app_t <= current_task;
                task_state[current_task] <= prqs_pkg::ST_READY;
              end
              task_state[hd] <= prqs_pkg::ST_RUNNING;
              current_task <= hd;
            end
          end
          default: ;
        endcase
      end
      if (cmd.link) begin
        // self-links of the unlinked/new task, then tail append
        if (func == prqs_pkg::FN_RESCHED || func == prqs_pkg::FN_DELETE) begin
          next_link[func == prqs_pkg::FN_RESCHED ? current_task : tid] <=
            (func == prqs_pkg::FN_RESCHED) ? current_task : tid;
          prev_link[func == prqs_pkg::FN_RESCHED ? current_task : tid] <=
            (func == prqs_pkg::FN_RESCHED) ? current_task : tid;
        end
        if (do_append) begin
          if (!queue_nonempty[app_lvl]) begin
            queue_head[app_lvl] <= app_t;
            queue_nonempty[app_lvl] <= 1'b1;
            next_link[app_t] <= app_t;
            prev_link[app_t] <= app_t;
          end else begin
            prev_link[app_t] <= a_tail;
            next_link[app_t] <= a_h;
            next_link[a_tail] <= app_t;
            prev_link[a_h] <= app_t;
          end
        end
      end
    end
  end

  assign r_error = err;
  assign r_status = task_state[tid];
  assign r_running = current_task;
  assign r_switch = sw;
endmodule

// ===== design/priority_ready_queue_scheduler_unit.sv =====
// Top level of the ready-queue scheduler: controller, datapath, result register.
// Depends on prqs_pkg, prqs_if, prqs_ctrl, prqs_dp.
// A command is taken in idle and passes through the exec, link and out states; one command in flight,
// so a new command is accepted only once the last result is loaded, and the out state waits while it is not taken.
// Reset (synchronous): task 0 running at the lowest level, all queues empty.
module priority_ready_queue_scheduler_unit (
  input logic         clk,
  input logic         rst,
  prqs_cmd_if.sink    cmd_in,
  prqs_rsp_if.source  rsp_out
);
  prqs_pkg::cmd_t cmd;
  logic r_error, r_switch;
  logic [1:0] r_status;
  logic [3:0] r_running;
  logic out_valid;

  prqs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
    .out_busy(out_valid && !rsp_out.ready), .cmd(cmd)
  );

  prqs_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_func(cmd_in.func), .in_tid(cmd_in.task_id),
    .in_prio(cmd_in.prio), .r_error(r_error), .r_status(r_status),
    .r_running(r_running), .r_switch(r_switch)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (rsp_out.ready) out_valid <= 1'b0;
    if (cmd.out_load) begin
      rsp_out.error <= r_error;
      rsp_out.task_status <= r_status;
      rsp_out.running_task <= r_running;
      rsp_out.switch_request <= r_switch;
    end
  end
  assign rsp_out.valid = out_valid;
endmodule

// ===== bench/prqs_sched_checker.sv =====
// Scheduler checker: watches command and result transfers, predicts each result, compares.
// Depends on prqs_pkg and prqs_if.
module prqs_sched_checker (
  input  logic       clk,
  input  logic       rst,
  prqs_cmd_if        cmd,
  prqs_rsp_if        rsp,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              error;
    prqs_pkg::tstate_t status;
    logic [3:0]        running;
    logic              sw_req;
  } sched_rsp_t;

  logic [3:0]        nxt [prqs_pkg::NumTasks];
  logic [3:0]        prv [prqs_pkg::NumTasks];
  logic [2:0]        lvl [prqs_pkg::NumTasks];
  prqs_pkg::tstate_t tst [prqs_pkg::NumTasks];
  logic [3:0]        head [prqs_pkg::NumPrios];
  logic              nonempty [prqs_pkg::NumPrios];
  logic [3:0]        cur;
  sched_rsp_t        rsp_fifo [$];

  function automatic void clear_model();
    for (int t = 0; t < prqs_pkg::NumTasks; t++) begin
      nxt[t] = 4'(t);
      prv[t] = 4'(t);
      lvl[t] = 3'(prqs_pkg::NumPrios - 1);
      tst[t] = prqs_pkg::ST_FREE;
    end
    for (int p = 0; p < prqs_pkg::NumPrios; p++) begin
      head[p] = '0;
      nonempty[p] = 1'b0;
    end
    tst[0] = prqs_pkg::ST_RUNNING;
    cur = '0;
  endfunction

  function automatic void push_tail(int p, logic [3:0] t);
    logic [3:0] h, tl;
    if (!nonempty[p]) begin
      head[p] = t;
      nonempty[p] = 1'b1;
      nxt[t] = t;
      prv[t] = t;
    end else begin
      h = head[p];
      tl = prv[h];
      prv[t] = tl;
      nxt[t] = h;
      nxt[tl] = t;
      prv[h] = t;
    end
  endfunction

  function automatic void pull_out(int p, logic [3:0] t);
    logic [3:0] n, q;
    n = nxt[t];
    q = prv[t];
    if (nonempty[p] && head[p] == t) begin
      if (n == t) nonempty[p] = 1'b0;
      else head[p] = n;
    end
    nxt[q] = n;
    prv[n] = q;
    nxt[t] = t;
    prv[t] = t;
  endfunction

  function automatic sched_rsp_t apply_cmd(prqs_pkg::func_t f, logic [3:0] id,
                                           logic [2:0] pr);
    sched_rsp_t r;
    logic [3:0] h;
    logic found;
    r = '0;
    case (f)
      prqs_pkg::FN_CREATE: begin
        if (id == cur || tst[id] == prqs_pkg::ST_READY || tst[id] == prqs_pkg::ST_RUNNING) begin
          r.error = 1'b1;
        end else begin
          push_tail(int'(pr), id);
          lvl[id] = pr;
          tst[id] = prqs_pkg::ST_READY;
        end
      end
      prqs_pkg::FN_DELETE: begin
        if (tst[id] == prqs_pkg::ST_FREE || tst[id] == prqs_pkg::ST_DELETED) begin
          r.error = 1'b1;
        end else begin
          if (tst[id] == prqs_pkg::ST_READY) pull_out(int'(lvl[id]), id);
          if (id == cur) r.sw_req = 1'b1;
          tst[id] = prqs_pkg::ST_DELETED;
          lvl[id] = 3'(prqs_pkg::NumPrios - 1);
        end
      end
      prqs_pkg::FN_QUERY: ;
      default: begin
        found = 1'b0;
        for (int i = 0; i <= lvl[cur]; i++) begin
          if (!found && nonempty[i]) begin
            found = 1'b1;
            h = head[i];
            pull_out(i, h);
            if (tst[cur] != prqs_pkg::ST_DELETED) begin
              push_tail(int'(lvl[cur]), cur);
              tst[cur] = prqs_pkg::ST_READY;
            end
            nxt[h] = h;
            prv[h] = h;
            tst[h] = prqs_pkg::ST_RUNNING;
            cur = h;
          end
        end
      end
    endcase
    r.status = tst[id];
    r.running = cur;
    return r;
  endfunction

  assign pending = rsp_fifo.size();

  always @(posedge clk) begin
    sched_rsp_t e;
    if (rst) begin
      clear_model();
      rsp_fifo.delete();
      fail_count <= 0;
    end else begin
      if (cmd.valid && cmd.ready)
        rsp_fifo.push_back(apply_cmd(prqs_pkg::func_t'(cmd.func), cmd.task_id, cmd.prio));
      if (rsp.valid && rsp.ready) begin
        if (rsp_fifo.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = rsp_fifo.pop_front();
          if (rsp.error !== e.error || rsp.task_status !== e.status
              || rsp.running_task !== e.running || rsp.switch_request !== e.sw_req)
            fail_count <= fail_count + 1;
          if (rsp.error !== e.error)
            $error("error: expected %0d, got %0d", e.error, rsp.error);
          if (rsp.task_status !== e.status)
            $error("task_status: expected %0d, got %0d", e.status, rsp.task_status);
          if (rsp.running_task !== e.running)
            $error("running_task: expected %0d, got %0d", e.running, rsp.running_task);
          if (rsp.switch_request !== e.sw_req)
            $error("switch_request: expected %0d, got %0d", e.sw_req,
                   rsp.switch_request);
        end
      end
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top: clock, reset, command stimulus, result stalls and verdict.
// Depends on prqs_pkg, prqs_if, prqs_sched_checker and the scheduler RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandCmds = 1700;
  localparam int IdleLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   cmd_sent;
  int   creates, deletes, switches;
  logic hold_off = 1'b0;

  prqs_cmd_if cmd_ch();
  prqs_rsp_if rsp_ch();

  priority_ready_queue_scheduler_unit i_dut (
    .clk(clk), .rst(rst), .cmd_in(cmd_ch.sink), .rsp_out(rsp_ch.source)
  );

  prqs_sched_checker i_chk (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .rsp(rsp_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sends one command and holds it until the transfer.
  task automatic send_cmd(prqs_pkg::func_t f, int id, int pr);
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= f;
    cmd_ch.task_id <= 4'(id);
    cmd_ch.prio <= 3'(pr);
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    cmd_sent++;
    if (f == prqs_pkg::FN_CREATE) creates++;
    if (f == prqs_pkg::FN_DELETE) deletes++;
  endtask

  task automatic idle_gap(int n);
    cmd_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random command mix on random task ids: creates, deletes, queries and reschedules.
  function automatic prqs_pkg::func_t pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return prqs_pkg::FN_CREATE;
    if (r < 55) return prqs_pkg::FN_DELETE;
    if (r < 70) return prqs_pkg::FN_QUERY;
    return prqs_pkg::FN_RESCHED;
  endfunction

  // Receiver stalls on its own pattern; one long hold-off mid-run.
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else if (hold_off) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(0, 7) != 0) || (cmd_sent < 40);
  end

  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready && rsp_ch.switch_request) switches++;
  end

  initial begin
    int burst;
    cmd_ch.valid <= 1'b0;
    cmd_ch.func <= prqs_pkg::FN_QUERY;
    cmd_ch.task_id <= '0;
    cmd_ch.prio <= '0;
    hold_off = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: every command and each special case.
    send_cmd(prqs_pkg::FN_QUERY, 0, 0);
    send_cmd(prqs_pkg::FN_CREATE, 0, 3);     // create of the running task
    send_cmd(prqs_pkg::FN_DELETE, 5, 0);     // delete of a free task
    send_cmd(prqs_pkg::FN_RESCHED, 9, 0);    // nothing ready
    send_cmd(prqs_pkg::FN_CREATE, 15, 7);
    send_cmd(prqs_pkg::FN_CREATE, 1, 0);
    send_cmd(prqs_pkg::FN_CREATE, 2, 0);
    send_cmd(prqs_pkg::FN_CREATE, 1, 5);     // already ready
    send_cmd(prqs_pkg::FN_CREATE, 3, 7);
    send_cmd(prqs_pkg::FN_RESCHED, 0, 0);
    send_cmd(prqs_pkg::FN_RESCHED, 0, 0);
    send_cmd(prqs_pkg::FN_DELETE, 2, 0);     // delete of the running task
    send_cmd(prqs_pkg::FN_CREATE, 2, 4);     // slot still current
    send_cmd(prqs_pkg::FN_DELETE, 2, 0);     // already deleted
    send_cmd(prqs_pkg::FN_RESCHED, 15, 7);
    send_cmd(prqs_pkg::FN_CREATE, 2, 4);
    send_cmd(prqs_pkg::FN_DELETE, 3, 7);     // delete from list middle
    send_cmd(prqs_pkg::FN_QUERY, 3, 2);
    send_cmd(prqs_pkg::FN_QUERY, 15, 5);
    send_cmd(prqs_pkg::FN_RESCHED, 1, 1);
    idle_gap(1);
    cmd_ch.task_id <= 4'hF;
    cmd_ch.prio <= 3'h7;
    cmd_ch.func <= prqs_pkg::FN_RESCHED;
    while (cmd_sent < 20 + RandCmds) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        if (cmd_sent == 20 + RandCmds / 2) begin
          hold_off <= 1'b1;
          fork
            begin
              repeat (300) @(posedge clk);
              hold_off <= 1'b0;
            end
          join_none
        end
        send_cmd(pick_func(), $urandom_range(0, 15), $urandom_range(0, 7));
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Ran %0d commands: %0d creates, %0d deletes, %0d deletes of the running task.",
             cmd_sent, creates, deletes, switches);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end
endmodule
